// ----- rtl/bmh_pkg.sv -----
// ----------------------------------------------------------------------------
// bmh_pkg
// Shared types and constants for the max priority queue: field widths,
// command and status codes, and the control bundle handed to every cell.
// ----------------------------------------------------------------------------
package bmh_pkg;

	localparam int KEY_W            = 32;
	localparam int COUNT_OUT_W      = 7;
	localparam int STATUS_W         = 2;
	localparam int CAPACITY_DEFAULT = 64;

	localparam logic CMD_PUSH = 1'b0;
	localparam logic CMD_POP  = 1'b1;

	localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

	typedef logic signed [KEY_W-1:0] key_t;

	typedef struct packed {
		logic push;
		logic pop;
		key_t key;
	} ctl_t;

endpackage

// ----- rtl/bmh_if.sv -----
// ----------------------------------------------------------------------------
// bmh_if
// Valid/ready channels of the priority queue: the command channel and the
// response channel.
// ----------------------------------------------------------------------------
interface bmh_cmd_if;
	logic          valid;
	logic          ready;
	logic          command;
	bmh_pkg::key_t value;

	modport source (output valid, output command, output value, input ready);
	modport sink   (input valid, input command, input value, output ready);
endinterface

interface bmh_rsp_if;
	logic                             valid;
	logic                             ready;
	bmh_pkg::key_t                    top_value;
	logic                             is_empty;
	logic [bmh_pkg::COUNT_OUT_W-1:0]  entry_count;
	logic [bmh_pkg::STATUS_W-1:0]     status;

	modport source (output valid, output top_value, output is_empty,
		output entry_count, output status, input ready);
	modport sink   (input valid, input top_value, input is_empty,
		input entry_count, input status, output ready);
endinterface

// ----- rtl/bmh_cell.sv -----
// ----------------------------------------------------------------------------
// bmh_cell
// One slot of the sorted chain. Keys stay ordered largest first; a push
// opens a gap at the insertion point and shifts smaller keys right, a pop
// shifts every key one slot left.
// ----------------------------------------------------------------------------
module bmh_cell #(
	parameter int IDX   = 0,
	parameter int CNT_W = 7
) (
	input  logic                 clk,
	input  bmh_pkg::ctl_t        ctl,
	input  logic [CNT_W-1:0]     count,
	input  bmh_pkg::key_t        prv_key,
	input  logic                 prv_ge,
	input  bmh_pkg::key_t        nxt_key,
	output bmh_pkg::key_t        key,
	output logic                 ge
);

	bmh_pkg::key_t key_q;
	logic          occupied;

	assign occupied = CNT_W'(IDX) < count;
	assign ge       = occupied && (key_q >= ctl.key);
	assign key      = key_q;

	always_ff @(posedge clk) begin
		priority if (ctl.push) begin
			if (!ge) begin
				key_q <= prv_ge ? ctl.key : prv_key;
			end
		end else if (ctl.pop) begin
			key_q <= nxt_key;
		end
	end

endmodule

// ----- rtl/binary_max_heap_priority_queue.sv -----
// Response: registered; valid rises in the cycle after the command transfer.
// Throughput: one command per cycle while the response side keeps up; push
//   and pop each finish in a single update of the whole cell chain.
// Reset: clears the entry count and the response valid; cell contents stay
//   undefined and are never read before they are written.
// ----------------------------------------------------------------------------
// binary_max_heap_priority_queue
// Max priority queue built from a chain of sorted key cells, one per entry,
// with a registered response carrying the top key, count and status.
// ----------------------------------------------------------------------------
module binary_max_heap_priority_queue #(
	parameter int CAPACITY = bmh_pkg::CAPACITY_DEFAULT
) (
	input  logic             clk,
	input  logic             arst_n,
	bmh_cmd_if.sink          cmd,
	bmh_rsp_if.source        rsp
);

	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic [CNT_W-1:0]             count_q;
	logic                         rsp_vld_q;
	logic [bmh_pkg::STATUS_W-1:0] status_q;
	logic                         accept;
	logic                         full;
	logic                         empty;
	bmh_pkg::ctl_t                ctl;
	bmh_pkg::key_t                keys [CAPACITY];
	logic                         ges  [CAPACITY];

	assign cmd.ready = rsp_vld_q ? rsp.ready : 1'b1;
	assign accept    = cmd.valid && cmd.ready;
	assign full      = count_q == CNT_W'(CAPACITY);
	assign empty     = count_q == '0;

	assign ctl.push = accept && (cmd.command == bmh_pkg::CMD_PUSH) && !full;
	assign ctl.pop  = accept && (cmd.command == bmh_pkg::CMD_POP) && !empty;
	assign ctl.key  = cmd.value;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		bmh_pkg::key_t prv_key;
		logic          prv_ge;
		bmh_pkg::key_t nxt_key;

		if (i == 0) begin : g_head
			assign prv_key = cmd.value;
			assign prv_ge  = 1'b1;
		end else begin : g_body
			assign prv_key = keys[i-1];
			assign prv_ge  = ges[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign nxt_key = keys[i];
		end else begin : g_mid
			assign nxt_key = keys[i+1];
		end

		bmh_cell #(
			.IDX   (i),
			.CNT_W (CNT_W)
		) u_cell (
			.clk     (clk),
			.ctl     (ctl),
			.count   (count_q),
			.prv_key (prv_key),
			.prv_ge  (prv_ge),
			.nxt_key (nxt_key),
			.key     (keys[i]),
			.ge      (ges[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			rsp_vld_q <= 1'b0;
		end else begin
			if (ctl.push) begin
				count_q <= count_q + CNT_W'(1);
			end else if (ctl.pop) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (accept) begin
				rsp_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			unique case (cmd.command)
				bmh_pkg::CMD_PUSH: status_q <= full ? bmh_pkg::ST_FULL : bmh_pkg::ST_DONE;
				bmh_pkg::CMD_POP:  status_q <= empty ? bmh_pkg::ST_EMPTY : bmh_pkg::ST_DONE;
				default:           status_q <= bmh_pkg::ST_DONE;
			endcase
		end
	end

	assign rsp.valid       = rsp_vld_q;
	assign rsp.top_value   = empty ? '0 : keys[0];
	assign rsp.is_empty    = empty;
	assign rsp.entry_count = bmh_pkg::COUNT_OUT_W'(count_q);
	assign rsp.status      = status_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.push |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("accepted push did not grow the count");

	a_full_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_vld_q && (status_q == bmh_pkg::ST_FULL) |-> full)
		else $error("full status with free slots");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_vld_q && (status_q == bmh_pkg::ST_EMPTY) |-> empty)
		else $error("empty status with stored entries");

	a_top_order: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q >= CNT_W'(2)) |-> (keys[0] >= keys[1]))
		else $error("top key smaller than its successor");
`endif

endmodule

// ----- verif/tb_binary_max_heap_priority_queue.sv -----
// ----------------------------------------------------------------------------
// tb_binary_max_heap_priority_queue
// Self-checking bench for the max priority queue. Commands go in over the
// command channel with random gaps; a behavioral heap in the bench predicts
// the top key, empty flag, count and status of every response. Responses are
// pulled with random stalls and checked in order against the predictions.
// ----------------------------------------------------------------------------
module tb_binary_max_heap_priority_queue;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH       = bmh_pkg::CAPACITY_DEFAULT;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_WAIT  = 8;
	localparam int MAX_GAP     = 18;

	typedef struct {
		bmh_pkg::key_t                   top;
		logic                            empty;
		logic [bmh_pkg::COUNT_OUT_W-1:0] count;
		logic [bmh_pkg::STATUS_W-1:0]    status;
	} answer_t;

	logic clk;
	logic arst_n;

	bmh_cmd_if cmd_ch ();
	bmh_rsp_if rsp_ch ();

	binary_max_heap_priority_queue #(
		.CAPACITY(DEPTH)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd_ch),
		.rsp   (rsp_ch)
	);

	bmh_pkg::key_t heap_keys [DEPTH];
	int            heap_fill;
	answer_t       awaited_answers [$];

	bit steady_flow;
	int mismatches;
	int answers_checked;
	int cycle_count;
	int push_count;
	int pop_count;
	int full_rejects;
	int empty_rejects;
	int peak_fill;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d responses outstanding",
				cycle_count, awaited_answers.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic int idle_draw();
		return steady_flow ? 0 : $urandom_range(0, MAX_GAP);
	endfunction

	function automatic bmh_pkg::key_t draw_key();
		case ($urandom_range(0, 5))
			0: return bmh_pkg::key_t'(32'h7FFF_FFFF);
			1: return bmh_pkg::key_t'(32'h8000_0000);
			2: return bmh_pkg::key_t'($urandom_range(0, 6)) - 3;
			3: return bmh_pkg::key_t'(32'h7FFF_FFFF) - bmh_pkg::key_t'($urandom_range(0, 2));
			default: return bmh_pkg::key_t'($urandom);
		endcase
	endfunction

	function automatic answer_t heap_outcome(logic command, bmh_pkg::key_t value);
		answer_t       a;
		int            pos;
		int            parent;
		int            left;
		int            right;
		int            best;
		bit            settled;
		bmh_pkg::key_t held;

		a.status = bmh_pkg::ST_DONE;
		if (command == bmh_pkg::CMD_PUSH) begin
			if (heap_fill >= DEPTH) begin
				a.status = bmh_pkg::ST_FULL;
			end else begin
				pos = heap_fill;
				heap_keys[pos] = value;
				heap_fill++;
				settled = 1'b0;
				while (pos > 0 && !settled) begin
					parent = (pos - 1) / 2;
					if (heap_keys[pos] > heap_keys[parent]) begin
						held = heap_keys[pos];
						heap_keys[pos] = heap_keys[parent];
						heap_keys[parent] = held;
						pos = parent;
					end else begin
						settled = 1'b1;
					end
				end
			end
		end else begin
			if (heap_fill == 0) begin
				a.status = bmh_pkg::ST_EMPTY;
			end else begin
				heap_fill--;
				heap_keys[0] = heap_keys[heap_fill];
				pos = 0;
				settled = 1'b0;
				while (!settled) begin
					left = 2 * pos + 1;
					right = 2 * pos + 2;
					best = pos;
					if (left < heap_fill && heap_keys[left] > heap_keys[best])
						best = left;
					if (right < heap_fill && heap_keys[right] > heap_keys[best])
						best = right;
					if (best == pos) begin
						settled = 1'b1;
					end else begin
						held = heap_keys[pos];
						heap_keys[pos] = heap_keys[best];
						heap_keys[best] = held;
						pos = best;
					end
				end
			end
		end
		a.top = (heap_fill > 0) ? heap_keys[0] : bmh_pkg::key_t'(0);
		a.empty = (heap_fill == 0);
		a.count = heap_fill[bmh_pkg::COUNT_OUT_W-1:0];
		return a;
	endfunction

	task automatic send_command(input logic command, input bmh_pkg::key_t value);
		int      gap;
		answer_t a;

		gap = idle_draw();
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.command <= command;
		cmd_ch.value <= value;
		do @(posedge clk); while (!cmd_ch.ready);
		a = heap_outcome(command, value);
		awaited_answers = {awaited_answers, a};
		if (command == bmh_pkg::CMD_PUSH)
			push_count++;
		else
			pop_count++;
		if (a.status == bmh_pkg::ST_FULL)
			full_rejects++;
		if (a.status == bmh_pkg::ST_EMPTY)
			empty_rejects++;
		if (heap_fill > peak_fill)
			peak_fill = heap_fill;
	endtask

	initial begin
		int gap;

		rsp_ch.ready = 1'b0;
		wait (arst_n);
		forever begin
			gap = idle_draw();
			if (gap > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
		end
	end

	always @(posedge clk) begin
		answer_t want;

		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (awaited_answers.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("cycle %0d: unexpected response top %0d count %0d status %0d",
						cycle_count, rsp_ch.top_value, rsp_ch.entry_count, rsp_ch.status);
			end else begin
				want = awaited_answers.pop_front();
				answers_checked++;
				if (rsp_ch.top_value !== want.top || rsp_ch.is_empty !== want.empty ||
					rsp_ch.entry_count !== want.count || rsp_ch.status !== want.status) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("cycle %0d: expected top %0d empty %0b count %0d status %0d,",
							cycle_count, want.top, want.empty, want.count, want.status);
						$display("  got top %0d empty %0b count %0d status %0d",
							rsp_ch.top_value, rsp_ch.is_empty, rsp_ch.entry_count,
							rsp_ch.status);
					end
				end
			end
		end
	end

	task automatic test_empty_pop();
		send_command(bmh_pkg::CMD_POP, bmh_pkg::key_t'($urandom));
		send_command(bmh_pkg::CMD_POP, bmh_pkg::key_t'(32'hFFFF_FFFF));
	endtask

	task automatic test_extreme_keys();
		steady_flow = 1'b1;
		send_command(bmh_pkg::CMD_PUSH, bmh_pkg::key_t'(32'h8000_0000));
		send_command(bmh_pkg::CMD_PUSH, bmh_pkg::key_t'(32'h7FFF_FFFF));
		send_command(bmh_pkg::CMD_PUSH, bmh_pkg::key_t'(0));
		send_command(bmh_pkg::CMD_PUSH, bmh_pkg::key_t'(-1));
		send_command(bmh_pkg::CMD_PUSH, bmh_pkg::key_t'(32'h7FFF_FFFF));
		send_command(bmh_pkg::CMD_PUSH, bmh_pkg::key_t'(1));
		steady_flow = 1'b0;
		repeat (6) send_command(bmh_pkg::CMD_POP, bmh_pkg::key_t'($urandom));
		send_command(bmh_pkg::CMD_POP, bmh_pkg::key_t'(0));
		// equal keys: left child wins ties on the way down
		repeat (4) send_command(bmh_pkg::CMD_PUSH, bmh_pkg::key_t'(-5));
		repeat (5) send_command(bmh_pkg::CMD_POP, bmh_pkg::key_t'($urandom));
	endtask

	task automatic test_fill_and_drain();
		repeat (DEPTH) send_command(bmh_pkg::CMD_PUSH, draw_key());
		send_command(bmh_pkg::CMD_PUSH, bmh_pkg::key_t'(32'h7FFF_FFFF));
		send_command(bmh_pkg::CMD_PUSH, bmh_pkg::key_t'(32'h8000_0000));
		send_command(bmh_pkg::CMD_PUSH, bmh_pkg::key_t'($urandom));
		repeat (DEPTH + 1) send_command(bmh_pkg::CMD_POP, bmh_pkg::key_t'($urandom));
	endtask

	task automatic test_random_traffic();
		int seg;
		int k;
		int push_pct;

		for (seg = 0; seg < 14; seg++) begin
			steady_flow = ($urandom_range(0, 3) == 0);
			// alternate three segments climbing toward full with three falling back toward empty; the last two are balanced
			push_pct = (seg % 6 < 3) ? 80 : 20;
			if (seg >= 12)
				push_pct = 50;
			for (k = 0; k < 50; k++) begin
				if ($urandom_range(0, 99) < push_pct)
					send_command(bmh_pkg::CMD_PUSH, draw_key());
				else
					send_command(bmh_pkg::CMD_POP, bmh_pkg::key_t'($urandom));
			end
		end
		steady_flow = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		cmd_ch.valid = 1'b0;
		cmd_ch.command = bmh_pkg::CMD_PUSH;
		cmd_ch.value = '0;
		steady_flow = 1'b0;
		heap_fill = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_pop();
		test_extreme_keys();
		test_fill_and_drain();
		test_random_traffic();

		cmd_ch.valid <= 1'b0;
		wait (awaited_answers.size() == 0);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("covered %0d pushes and %0d pops, peak fill %0d of %0d",
			push_count, pop_count, peak_fill, DEPTH);
		$display("rejected %0d pushes when full, %0d pops when empty; %0d responses checked",
			full_rejects, empty_rejects, answers_checked);
		if (mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
